// ===== rtl/vbd_pkg.sv =====
// shared constants, types and codes of the viterbi beam decoder
package vbd_pkg;

    localparam int STATE_CNT  = 16;
    localparam int STATE_W    = 4;
    localparam int MAX_LAG    = 32;
    localparam int LAG_W      = 5;
    localparam int STEP_W     = 6;
    localparam int PROB_W     = 16;
    localparam int SUM_W      = 20;
    localparam int QUOT_W     = 17;
    localparam int ROW_W      = STATE_CNT * STATE_W;
    localparam int TRANS_AW   = 2 * STATE_W;
    localparam int TRANS_N    = STATE_CNT * STATE_CNT;
    localparam int CNT_W      = 9;

    localparam logic [PROB_W-1:0] MAX_Q = '1;

    typedef enum logic [2:0] {
        ACT_LOAD_TRANS = 3'd0,
        ACT_LOAD_PRIOR = 3'd1,
        ACT_START      = 3'd2,
        ACT_EMISSION   = 3'd3,
        ACT_QUERY      = 3'd4
    } t_action;

    localparam logic KIND_STEP  = 1'b0;
    localparam logic KIND_TRACE = 1'b1;

    typedef enum logic [3:0] {
        S_IDLE,
        S_START,
        S_MAX,
        S_EMIT,
        S_CHECK,
        S_DIV,
        S_DIVW,
        S_REPORT,
        S_TRRD,
        S_TRUSE,
        S_TROUT
    } t_state;

endpackage

// ===== rtl/vbd_ram.sv =====
// generic single-write, single-read synchronous ram with registered read data
module vbd_ram #(
    parameter int DEPTH = 256,
    parameter int WIDTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

// ===== rtl/vbd_div.sv =====
// bit-serial divider for score normalization, one quotient bit per cycle
module vbd_div (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [vbd_pkg::PROB_W-1:0]  i_num,
    input  logic [vbd_pkg::SUM_W-1:0]   i_den,
    output logic                        o_done,
    output logic [vbd_pkg::QUOT_W-1:0]  o_quot
);
    import vbd_pkg::*;

    logic [SUM_W:0]  r_rem;
    logic [QUOT_W-1:0] r_q;
    logic [4:0]      r_cnt;
    logic            r_busy;
    logic            r_done;
    logic            w_ge;
    logic [SUM_W:0]  w_diff;

    assign w_ge   = r_rem >= {1'b0, i_den};
    assign w_diff = w_ge ? (r_rem - {1'b0, i_den}) : r_rem;
    assign o_done = r_done;
    assign o_quot = r_q;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                // numerator never exceeds the divisor, so the first step needs no shift
                r_rem  <= {{(SUM_W+1-PROB_W){1'b0}}, i_num};
                r_q    <= '0;
                r_cnt  <= 5'(QUOT_W);
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_rem <= {w_diff[SUM_W-1:0], 1'b0};
                r_q   <= {r_q[QUOT_W-2:0], w_ge};
                r_cnt <= r_cnt - 5'd1;
                if (r_cnt == 5'd1) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end
endmodule

// ===== rtl/hmm_viterbi_beam_decoder.sv =====
// top level of the online viterbi decoder with beam pruning and bounded traceback
//
//  channel | signals                          | direction
//  --------+----------------------------------+----------
//  input   | i_valid / o_ready, i_action ...  | in
//  result  | o_valid / i_ready, o_result_kind | out
//  config  | i_cfg_we, i_cfg_idx, i_cfg_data  | in
//
// loads are written on acceptance; start scans the priors one state at a time
// and stops early if their sum overflows; an observation step runs the transition
// sweep (one transition ram read per cycle), emission weighting and the serial
// divider for each state unless the sum is zero; a query reads the ring once per traced step
// and then emits the elements; synchronous active-low reset, no clearing pass
// results wait in an output register; a stalled result only blocks result-producing states
module hmm_viterbi_beam_decoder (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    output logic                            o_ready,
    input  logic [2:0]                      i_action,
    input  logic [vbd_pkg::STATE_W-1:0]     i_source_state,
    input  logic [vbd_pkg::STATE_W-1:0]     i_target_state,
    input  logic [vbd_pkg::PROB_W-1:0]      i_prob_value,
    input  logic                            i_end_of_observation,
    input  logic [vbd_pkg::STEP_W-1:0]      i_steps_back,
    output logic                            o_valid,
    input  logic                            i_ready,
    output logic                            o_result_kind,
    output logic [vbd_pkg::STATE_W-1:0]     o_state_id,
    output logic                            o_status,
    output logic                            o_last,
    input  logic                            i_cfg_we,
    input  logic                            i_cfg_idx,
    input  logic [vbd_pkg::PROB_W-1:0]      i_cfg_data
);
    import vbd_pkg::*;

    t_state r_state, n_state;

    logic [PROB_W-1:0]  r_thr;
    logic [STEP_W-1:0]  r_hlim;
    logic [TRANS_N-1:0] r_tvalid;
    logic               r_tv_q;
    logic [PROB_W-1:0]  r_prior [STATE_CNT];
    logic [PROB_W-1:0]  r_emis  [STATE_CNT];
    logic [PROB_W-1:0]  r_prev  [STATE_CNT];
    logic [PROB_W-1:0]  r_cur   [STATE_CNT];
    logic [STATE_CNT-1:0] r_active;
    logic [LAG_W-1:0]   r_head;
    logic [LAG_W-1:0]   r_slot;
    logic [STEP_W-1:0]  r_stored;
    logic [STATE_W-1:0] r_best;
    logic [CNT_W-1:0]   r_cnt;
    logic               r_s1_v;
    logic [STATE_W-1:0] r_s1_i, r_s1_j;
    logic               r_p2_v;
    logic [STATE_W-1:0] r_p2_i, r_p2_j;
    logic [PROB_W-1:0]  r_p2_prod;
    logic [STATE_W-1:0] r_bprow [STATE_CNT];
    logic [SUM_W-1:0]   r_sum;
    logic [SUM_W:0]     r_added;
    logic [PROB_W-1:0]  r_top;
    logic               r_status;
    logic [STEP_W-1:0]  r_n, r_k;
    logic [STATE_W-1:0] r_id;
    logic [STATE_W-1:0] r_seq [MAX_LAG];
    logic               r_ov;
    logic               r_okind, r_ostatus, r_olast;
    logic [STATE_W-1:0] r_ostate;

    logic               w_acc;
    logic               w_out_free;
    logic [STEP_W-1:0]  w_lim;
    logic [PROB_W-1:0]  w_tq;
    logic [PROB_W-1:0]  w_t;
    logic [2*PROB_W-1:0] w_mprod;
    logic [2*PROB_W-1:0] w_eprod;
    logic [SUM_W:0]     w_added_n;
    logic [ROW_W-1:0]   w_row_wr;
    logic [ROW_W-1:0]   w_row_rd;
    logic [LAG_W-1:0]   w_ring_raddr;
    logic [STATE_W-1:0] w_trace_id;
    logic [STATE_W-1:0] w_j;
    logic               w_div_start;
    logic               w_div_done;
    logic [QUOT_W-1:0]  w_quot;
    logic [PROB_W-1:0]  w_v;
    logic [STEP_W-1:0]  w_nq;

    assign w_acc      = i_valid && o_ready;
    assign o_ready    = (r_state == S_IDLE);
    assign w_out_free = !r_ov || i_ready;
    assign w_j        = r_cnt[STATE_W-1:0];

    assign o_valid       = r_ov;
    assign o_result_kind = r_okind;
    assign o_state_id    = r_ostate;
    assign o_status      = r_ostatus;
    assign o_last        = r_olast;

    always_comb begin
        if (r_hlim == '0) begin
            w_lim = STEP_W'(1);
        end else if (r_hlim > STEP_W'(MAX_LAG)) begin
            w_lim = STEP_W'(MAX_LAG);
        end else begin
            w_lim = r_hlim;
        end
    end

    assign w_nq = (i_steps_back < r_stored) ? i_steps_back : r_stored;

    // transition table, entries never written read as zero through the valid bits
    vbd_ram #(.DEPTH(TRANS_N), .WIDTH(PROB_W)) u_trans (
        .i_clk   (i_clk),
        .i_we    (w_acc && i_action == ACT_LOAD_TRANS),
        .i_waddr ({i_source_state, i_target_state}),
        .i_wdata (i_prob_value),
        .i_raddr (r_cnt[TRANS_AW-1:0]),
        .o_rdata (w_tq)
    );

    assign w_t     = r_tv_q ? w_tq : '0;
    assign w_mprod = r_prev[r_s1_i] * w_t;
    assign w_eprod = r_cur[w_j] * r_emis[w_j];

    always_comb begin
        for (int s = 0; s < STATE_CNT; s++) begin
            w_row_wr[s*STATE_W +: STATE_W] = r_bprow[s];
        end
    end

    assign w_ring_raddr = r_head - LAG_W'(1) - r_k[LAG_W-1:0];

    vbd_ram #(.DEPTH(MAX_LAG), .WIDTH(ROW_W)) u_ring (
        .i_clk   (i_clk),
        .i_we    (r_state == S_EMIT && r_cnt == '0),
        .i_waddr (r_slot),
        .i_wdata (w_row_wr),
        .i_raddr (w_ring_raddr),
        .o_rdata (w_row_rd)
    );

    assign w_trace_id = w_row_rd[r_id*STATE_W +: STATE_W];

    assign w_div_start = (r_state == S_DIV);

    vbd_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (r_cur[w_j]),
        .i_den   (r_sum),
        .o_done  (w_div_done),
        .o_quot  (w_quot)
    );

    assign w_v       = (w_quot > {1'b0, MAX_Q}) ? MAX_Q : w_quot[PROB_W-1:0];
    assign w_added_n = r_added + {{(SUM_W+1-PROB_W){1'b0}}, r_prior[w_j]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_acc) begin
                    case (i_action)
                        ACT_START:    n_state = S_START;
                        ACT_EMISSION: n_state = i_end_of_observation ? S_MAX : S_IDLE;
                        ACT_QUERY:    n_state = (w_nq == '0) ? S_TROUT : S_TRRD;
                        default:      n_state = S_IDLE;
                    endcase
                end
            end
            S_START: begin
                if (w_added_n[SUM_W:PROB_W] != '0 || w_j == STATE_W'(STATE_CNT - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_MAX:    n_state = (r_cnt == CNT_W'(TRANS_N + 1)) ? S_EMIT : S_MAX;
            S_EMIT:   n_state = (w_j == STATE_W'(STATE_CNT - 1)) ? S_CHECK : S_EMIT;
            S_CHECK:  n_state = (r_sum == '0) ? S_REPORT : S_DIV;
            S_DIV:    n_state = S_DIVW;
            S_DIVW: begin
                if (w_div_done) begin
                    n_state = (w_j == STATE_W'(STATE_CNT - 1)) ? S_REPORT : S_DIV;
                end
            end
            S_REPORT: n_state = w_out_free ? S_IDLE : S_REPORT;
            S_TRRD:   n_state = S_TRUSE;
            S_TRUSE:  n_state = (r_k + STEP_W'(1) == r_n) ? S_TROUT : S_TRRD;
            S_TROUT:  n_state = (w_out_free && r_k == r_n) ? S_IDLE : S_TROUT;
            default:  n_state = S_IDLE;
        endcase
    end

    // configuration registers and valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr    <= '0;
            r_hlim   <= STEP_W'(MAX_LAG);
            r_tvalid <= '0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_idx == 1'b0) begin
                    r_thr <= i_cfg_data;
                end else begin
                    r_hlim <= i_cfg_data[STEP_W-1:0];
                end
            end
            if (w_acc && i_action == ACT_LOAD_TRANS) begin
                r_tvalid[{i_source_state, i_target_state}] <= 1'b1;
            end
        end
        r_tv_q <= r_tvalid[r_cnt[TRANS_AW-1:0]];
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else begin
            if (r_ov && i_ready) begin
                r_ov <= 1'b0;
            end
            if (r_state == S_REPORT && w_out_free) begin
                r_ov      <= 1'b1;
                r_okind   <= KIND_STEP;
                r_ostate  <= r_best;
                r_ostatus <= r_status;
                r_olast   <= 1'b1;
            end else if (r_state == S_TROUT && w_out_free) begin
                r_ov      <= 1'b1;
                r_okind   <= KIND_TRACE;
                r_ostate  <= (r_k == r_n) ? r_best : r_seq[r_k[LAG_W-1:0]];
                r_ostatus <= 1'b0;
                r_olast   <= (r_k == r_n);
            end
        end
    end

    // transition sweep pipeline: ram read, multiply, compare and update
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
            r_p2_v <= 1'b0;
        end else begin
            r_s1_v <= (r_state == S_MAX) && (r_cnt < CNT_W'(TRANS_N));
            r_p2_v <= r_s1_v && r_active[r_s1_i] && (w_t != '0);
        end
        r_s1_i    <= r_cnt[TRANS_AW-1:STATE_W];
        r_s1_j    <= r_cnt[STATE_W-1:0];
        r_p2_i    <= r_s1_i;
        r_p2_j    <= r_s1_j;
        r_p2_prod <= w_mprod[2*PROB_W-1:PROB_W];
    end

    // decoder state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= '0;
            r_head   <= '0;
            r_stored <= '0;
            r_best   <= '0;
            r_cnt    <= '0;
            for (int s = 0; s < STATE_CNT; s++) begin
                r_prior[s] <= '0;
                r_prev[s]  <= '0;
                r_cur[s]   <= '0;
            end
        end else begin
            case (r_state)
                S_IDLE: begin
                    r_cnt <= '0;
                    if (w_acc) begin
                        case (i_action)
                            ACT_LOAD_PRIOR: r_prior[i_target_state] <= i_prob_value;
                            ACT_START: begin
                                for (int s = 0; s < STATE_CNT; s++) begin
                                    r_prev[s] <= '0;
                                    r_cur[s]  <= '0;
                                end
                                r_active <= '0;
                                r_head   <= '0;
                                r_stored <= '0;
                                r_best   <= '0;
                                r_added  <= '0;
                                r_top    <= '0;
                            end
                            ACT_EMISSION: begin
                                r_emis[i_target_state] <= i_prob_value;
                                if (i_end_of_observation) begin
                                    for (int s = 0; s < STATE_CNT; s++) begin
                                        r_prev[s]  <= r_cur[s];
                                        r_cur[s]   <= '0;
                                        r_bprow[s] <= '0;
                                    end
                                    r_slot   <= r_head;
                                    r_head   <= r_head + LAG_W'(1);
                                    r_stored <= (r_stored < w_lim) ? r_stored + STEP_W'(1)
                                                                   : w_lim;
                                    r_sum    <= '0;
                                end
                            end
                            ACT_QUERY: begin
                                r_n  <= w_nq;
                                r_k  <= '0;
                                r_id <= r_best;
                            end
                            default: ;
                        endcase
                    end
                end
                S_START: begin
                    if (r_prior[w_j] != '0) begin
                        r_cur[w_j]    <= r_prior[w_j];
                        r_active[w_j] <= 1'b1;
                        r_added       <= w_added_n;
                    end
                    if (r_prior[w_j] > r_top) begin
                        r_top  <= r_prior[w_j];
                        r_best <= w_j;
                    end
                    r_cnt <= r_cnt + CNT_W'(1);
                end
                S_MAX: begin
                    if (r_p2_v && r_p2_prod > r_cur[r_p2_j]) begin
                        r_cur[r_p2_j]   <= r_p2_prod;
                        r_bprow[r_p2_j] <= r_p2_i;
                    end
                    r_cnt <= (r_cnt == CNT_W'(TRANS_N + 1)) ? '0 : r_cnt + CNT_W'(1);
                end
                S_EMIT: begin
                    if (r_cur[w_j] != '0) begin
                        r_cur[w_j] <= w_eprod[2*PROB_W-1:PROB_W];
                        r_sum      <= r_sum + SUM_W'(w_eprod[2*PROB_W-1:PROB_W]);
                    end
                    r_cnt <= (w_j == STATE_W'(STATE_CNT - 1)) ? '0 : r_cnt + CNT_W'(1);
                end
                S_CHECK: begin
                    r_active <= '0;
                    r_top    <= '0;
                    r_status <= (r_sum == '0);
                    if (r_sum == '0) begin
                        // zero sum leaves every score at zero
                        for (int s = 0; s < STATE_CNT; s++) begin
                            r_cur[s] <= '0;
                        end
                    end
                end
                S_DIVW: begin
                    if (w_div_done) begin
                        r_cur[w_j] <= w_v;
                        if (w_v > r_thr) begin
                            r_active[w_j] <= 1'b1;
                            if (w_v > r_top) begin
                                r_top  <= w_v;
                                r_best <= w_j;
                            end
                        end
                        r_cnt <= r_cnt + CNT_W'(1);
                    end
                end
                S_TRUSE: begin
                    r_seq[LAG_W'(r_n - STEP_W'(1) - r_k)] <= w_trace_id;
                    r_id <= w_trace_id;
                    r_k  <= (r_k + STEP_W'(1) == r_n) ? '0 : r_k + STEP_W'(1);
                end
                S_TROUT: begin
                    if (w_out_free && r_k != r_n) begin
                        r_k <= r_k + STEP_W'(1);
                    end
                end
                default: ;
            endcase
        end
    end
endmodule
